// ===== hw/rtl/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbc_pkg
// shared types and constants for the block buffer cache
// ----------------------------------------------------------------------------
package lbc_pkg;
  localparam int unsigned NumBuffersDef = 32;
  localparam int unsigned CountWidthDef = 8;
  localparam int unsigned SlotW = 5;
  localparam int unsigned DevW = 8;
  localparam int unsigned BlkW = 32;
  localparam int unsigned OutCntW = 8;

  typedef enum logic [1:0] {
    KIND_GET     = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_PIN     = 2'd2,
    KIND_UNPIN   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_UNDER    = 2'd2,
    ST_OVER     = 2'd3
  } status_e;

  typedef struct packed {
    logic scan_start;
    logic scan_step;
    logic victim_mode;
    logic apply_get;
    logic apply_slot;
    logic age_start;
    logic age_step;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic hit_found;
    logic need_age;
  } stat_t;
endpackage

// ===== hw/rtl/lbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbc_ctrl
// sequencer for scans, update and rank aging
// ----------------------------------------------------------------------------
module lbc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    kind_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  lbc_pkg::stat_t stat_i,
  output lbc_pkg::cmd_t  cmd_o
);
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_HSCAN  = 6'b000010,
    S_VSCAN  = 6'b000100,
    S_APPLY  = 6'b001000,
    S_AGE    = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic is_get_q, is_get_d;
  logic acc;

  assign in_stall_o = (state_q != S_IDLE);
  assign acc = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    is_get_d = is_get_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          is_get_d = (kind_i == lbc_pkg::KIND_GET);
          cmd_o.scan_start = 1'b1;
          state_d = (kind_i == lbc_pkg::KIND_GET) ? S_HSCAN : S_APPLY;
        end
      end
      S_HSCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_VSCAN;
        end
      end
      S_VSCAN: begin
        if (stat_i.hit_found) begin
          state_d = S_APPLY;
        end else begin
          cmd_o.scan_step = 1'b1;
          cmd_o.victim_mode = 1'b1;
          if (stat_i.scan_last) begin
            state_d = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        cmd_o.apply_get = is_get_q;
        cmd_o.apply_slot = !is_get_q;
        if (!is_get_q && stat_i.need_age) begin
          cmd_o.age_start = 1'b1;
          state_d = S_AGE;
        end else begin
          state_d = S_OUT;
        end
      end
      S_AGE: begin
        cmd_o.age_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      is_get_q <= 1'b0;
    end else begin
      state_q <= state_d;
      is_get_q <= is_get_d;
    end
  end
endmodule

// ===== hw/rtl/lbc_dpath.sv =====
// ----------------------------------------------------------------------------
// lbc_dpath
// entry table, scan pointer, best-entry tracking and result register
// ----------------------------------------------------------------------------
module lbc_dpath #(
  parameter int unsigned NUM_BUFFERS = lbc_pkg::NumBuffersDef,
  parameter int unsigned COUNT_WIDTH = lbc_pkg::CountWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      acc_i,
  input  logic [1:0]                kind_i,
  input  logic [lbc_pkg::DevW-1:0]  device_i,
  input  logic [lbc_pkg::BlkW-1:0]  block_number_i,
  input  logic [lbc_pkg::SlotW-1:0] slot_i,
  input  lbc_pkg::cmd_t             cmd_i,
  output lbc_pkg::stat_t            stat_o,
  output logic [lbc_pkg::SlotW-1:0] buffer_slot_o,
  output logic                      needs_load_o,
  output logic [1:0]                status_o,
  output logic [lbc_pkg::OutCntW-1:0] ref_count_o
);
  localparam int unsigned IdxW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_BUFFERS - 1);

  logic [lbc_pkg::DevW-1:0] tdev_q [NUM_BUFFERS];
  logic [lbc_pkg::BlkW-1:0] tblk_q [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0]   vld_q;
  logic [COUNT_WIDTH-1:0]   cnt_q [NUM_BUFFERS];
  logic [IdxW-1:0]          rank_q [NUM_BUFFERS];

  logic [1:0]                kind_q;
  logic [lbc_pkg::DevW-1:0]  dev_q;
  logic [lbc_pkg::BlkW-1:0]  blk_q;
  logic [lbc_pkg::SlotW-1:0] slot_q;
  logic [IdxW-1:0]           ptr_q;
  logic                      hit_q, free_q;
  logic [IdxW-1:0]           best_q, brank_q, arank_q;
  logic                      slot_ok;
  logic [IdxW-1:0]           sidx;

  logic [lbc_pkg::SlotW-1:0] rslot_q;
  logic                      rload_q;
  logic [1:0]                rstat_q;
  logic [COUNT_WIDTH-1:0]    rcnt_q;

  // combinational next value for slot operations
  logic [COUNT_WIDTH-1:0] sc;
  logic [1:0]             sst;
  logic                   sage;

  assign slot_ok = ({{(32-lbc_pkg::SlotW){1'b0}}, slot_q} < 32'(NUM_BUFFERS));
  assign sidx = IdxW'(slot_q);
  assign stat_o.scan_last = (ptr_q == LastIdx);
  assign stat_o.hit_found = hit_q;
  assign stat_o.need_age = slot_ok && sage;

  assign buffer_slot_o = rslot_q;
  assign needs_load_o = rload_q;
  assign status_o = rstat_q;
  assign ref_count_o = lbc_pkg::OutCntW'({{16{1'b0}}, rcnt_q});

  always_comb begin
    sc = cnt_q[sidx];
    sst = lbc_pkg::ST_OK;
    sage = 1'b0;
    if (kind_q == lbc_pkg::KIND_PIN) begin
      if (sc == CountMax) sst = lbc_pkg::ST_OVER;
      else sc = sc + 1'b1;
    end else begin
      if (sc == '0) sst = lbc_pkg::ST_UNDER;
      else begin
        sc = sc - 1'b1;
        sage = (kind_q == lbc_pkg::KIND_RELEASE) && (sc == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tdev_q[i] <= '0;
        tblk_q[i] <= '0;
        cnt_q[i] <= '0;
        rank_q[i] <= IdxW'(i);
      end
      vld_q <= '0;
      ptr_q <= '0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
      kind_q <= '0;
      dev_q <= '0;
      blk_q <= '0;
      slot_q <= '0;
      best_q <= '0;
      brank_q <= '0;
      arank_q <= '0;
      rslot_q <= '0;
      rload_q <= 1'b0;
      rstat_q <= lbc_pkg::ST_OK;
      rcnt_q <= '0;
    end else begin
      if (acc_i) begin
        kind_q <= kind_i;
        dev_q <= device_i;
        blk_q <= block_number_i;
        slot_q <= slot_i;
      end
      if (cmd_i.scan_start || cmd_i.age_start) begin
        ptr_q <= '0;
        hit_q <= 1'b0;
        free_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        ptr_q <= (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
        if (!cmd_i.victim_mode) begin
          if (tdev_q[ptr_q] == dev_q && tblk_q[ptr_q] == blk_q &&
              (!hit_q || rank_q[ptr_q] > brank_q)) begin
            hit_q <= 1'b1;
            best_q <= ptr_q;
            brank_q <= rank_q[ptr_q];
          end
        end else begin
          if (cnt_q[ptr_q] == '0 && (!free_q || rank_q[ptr_q] < brank_q)) begin
            free_q <= 1'b1;
            best_q <= ptr_q;
            brank_q <= rank_q[ptr_q];
          end
        end
      end else if (cmd_i.age_step) begin
        ptr_q <= (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
      end
      if (cmd_i.apply_get) begin
        rload_q <= 1'b0;
        rstat_q <= lbc_pkg::ST_OK;
        if (hit_q) begin
          rslot_q <= lbc_pkg::SlotW'({{8{1'b0}}, best_q});
          rload_q <= !vld_q[best_q];
          vld_q[best_q] <= 1'b1;
          if (cnt_q[best_q] == CountMax) begin
            rstat_q <= lbc_pkg::ST_OVER;
            rcnt_q <= CountMax;
          end else begin
            cnt_q[best_q] <= cnt_q[best_q] + 1'b1;
            rcnt_q <= cnt_q[best_q] + 1'b1;
          end
        end else if (free_q) begin
          rslot_q <= lbc_pkg::SlotW'({{8{1'b0}}, best_q});
          rload_q <= 1'b1;
          vld_q[best_q] <= 1'b1;
          tdev_q[best_q] <= dev_q;
          tblk_q[best_q] <= blk_q;
          cnt_q[best_q] <= COUNT_WIDTH'(1);
          rcnt_q <= COUNT_WIDTH'(1);
        end else begin
          rslot_q <= '0;
          rstat_q <= lbc_pkg::ST_NO_FREE;
          rcnt_q <= '0;
        end
      end
      if (cmd_i.apply_slot) begin
        rslot_q <= slot_q;
        rload_q <= 1'b0;
        if (slot_ok) begin
          cnt_q[sidx] <= sc;
          rcnt_q <= sc;
          rstat_q <= sst;
          arank_q <= rank_q[sidx];
        end else begin
          rcnt_q <= '0;
          rstat_q <= lbc_pkg::ST_OK;
        end
      end
      if (cmd_i.age_step) begin
        if (ptr_q == sidx) rank_q[ptr_q] <= LastIdx;
        else if (rank_q[ptr_q] > arank_q) rank_q[ptr_q] <= rank_q[ptr_q] - 1'b1;
      end
    end
  end
endmodule

// ===== hw/rtl/lru_block_buffer_cache.sv =====
// ----------------------------------------------------------------------------
// lru_block_buffer_cache
// reference-counted buffer table with recency replacement
// ----------------------------------------------------------------------------
// channel | valid / stall        | payload
// in      | in_valid_i/in_stall_o | kind, device, block_number, slot
// out     | out_valid_o/out_stall_i | buffer_slot, needs_load, status, ref_count
// a get runs a full tag scan, then a victim scan that is skipped after a hit,
// then the update; release/pin/unpin go straight to the update, plus an aging
// pass when a release ages the recency ranks; one entry visited per cycle
// reset clears tags, counts and valid bits at once and sets ranks to index
// the result register holds while out_stall_i is high; no new request meanwhile
module lru_block_buffer_cache #(
  parameter int unsigned NUM_BUFFERS = lbc_pkg::NumBuffersDef,
  parameter int unsigned COUNT_WIDTH = lbc_pkg::CountWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic [lbc_pkg::DevW-1:0]    device_i,
  input  logic [lbc_pkg::BlkW-1:0]    block_number_i,
  input  logic [lbc_pkg::SlotW-1:0]   slot_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lbc_pkg::SlotW-1:0]   buffer_slot_o,
  output logic                        needs_load_o,
  output logic [1:0]                  status_o,
  output logic [lbc_pkg::OutCntW-1:0] ref_count_o
);
  lbc_pkg::cmd_t  cmd;
  lbc_pkg::stat_t stat;

  lbc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .kind_i, .in_stall_o, .out_valid_o,
    .out_stall_i, .stat_i(stat), .cmd_o(cmd)
  );

  lbc_dpath #(.NUM_BUFFERS(NUM_BUFFERS), .COUNT_WIDTH(COUNT_WIDTH)) u_dpath (
    .clk_i, .rst_ni, .acc_i(in_valid_i && !in_stall_o), .kind_i, .device_i,
    .block_number_i, .slot_i, .cmd_i(cmd), .stat_o(stat), .buffer_slot_o,
    .needs_load_o, .status_o, .ref_count_o
  );
endmodule
